FILE: rtl/qedc_pkg.sv
// ----------------------------------------------------------------------------
// qedc_pkg
// Shared types, constants and lookup functions for the quadrature encoder
// detent counter.
// ----------------------------------------------------------------------------
package qedc_pkg;

   localparam int unsigned PHASE_BITS    = 2;
   localparam int unsigned ACCUM_BITS    = 5;
   localparam int unsigned THR_BITS      = 3;
   localparam int unsigned MASK_BITS     = 4;
   localparam int unsigned OUT_CHANNELS  = 4;
   localparam int unsigned OUT_BITS      = 16;
   localparam int unsigned SAMPLE_BITS   = 8;
   localparam int unsigned CSR_IDX_BITS  = 8;
   localparam int unsigned CSR_DATA_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT_MASK      = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DETENT_THRESHOLD = 8'd1;

   localparam logic [MASK_BITS-1:0] INVERT_MASK_RESET      = 4'd1;
   localparam logic [THR_BITS-1:0]  DETENT_THRESHOLD_RESET = 3'd3;

   typedef struct packed {
      logic                advance;
      logic                invert;
      logic [THR_BITS-1:0] threshold;
   } lane_ctrl_type;

   // quarter step from previous and current phase
   function automatic logic signed [1:0] step_of(input logic [3:0] idx);
      logic signed [1:0] s;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
         default: s = 2'sd0;
      endcase
      return s;
   endfunction

   // low bit of the pin pair of an output channel
   function automatic logic [2:0] pin_shift(input logic [1:0] ch);
      logic [2:0] sh;
      case (ch)
         2'd0: sh = 3'd6;
         2'd1: sh = 3'd2;
         2'd2: sh = 3'd4;
         default: sh = 3'd0;
      endcase
      return sh;
   endfunction

endpackage

FILE: rtl/qedc_lane.sv
// ----------------------------------------------------------------------------
// qedc_lane
// One encoder channel: transition lookup, sub-step accumulator and wrapping
// detent count.
// ----------------------------------------------------------------------------
module qedc_lane #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  qedc_pkg::lane_ctrl_type             ctrl,
   input  logic [qedc_pkg::PHASE_BITS-1:0]     phase,
   output logic [COUNT_BITS-1:0]               count_next
);

   logic [qedc_pkg::PHASE_BITS-1:0]        phase_ff;
   logic signed [qedc_pkg::ACCUM_BITS-1:0] accum_ff;
   logic signed [qedc_pkg::ACCUM_BITS-1:0] accum_in;
   logic [COUNT_BITS-1:0]                  count_ff;
   logic [COUNT_BITS-1:0]                  count_in;
   logic signed [qedc_pkg::ACCUM_BITS-1:0] sum;
   logic signed [qedc_pkg::ACCUM_BITS-1:0] thr_pos;
   logic signed [qedc_pkg::ACCUM_BITS-1:0] thr_neg;
   logic signed [1:0]                      step;

   always_comb begin
      step    = qedc_pkg::step_of({phase_ff, phase});
      sum     = accum_ff + qedc_pkg::ACCUM_BITS'(step);
      thr_pos = $signed({2'b00, ctrl.threshold});
      thr_neg = -thr_pos;
      accum_in = sum;
      count_in = count_ff;
      if (sum > thr_pos) begin
         accum_in = '0;
         count_in = ctrl.invert ? count_ff - COUNT_BITS'(1) : count_ff + COUNT_BITS'(1);
      end else if (sum < thr_neg) begin
         accum_in = '0;
         count_in = ctrl.invert ? count_ff + COUNT_BITS'(1) : count_ff - COUNT_BITS'(1);
      end
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         accum_ff <= '0;
         count_ff <= '0;
      end else if (ctrl.advance) begin
         phase_ff <= phase;
         accum_ff <= accum_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff) |->
         count_ff == $past(count_ff) + COUNT_BITS'(1) ||
         count_ff == $past(count_ff) - COUNT_BITS'(1))
      else $error("detent count moved by more than one");
   a_count_clears_accum: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff) |-> accum_ff == '0)
      else $error("accumulator not cleared on detent step");
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(ctrl.advance) |-> $stable(count_ff) && $stable(accum_ff))
      else $error("lane state changed without an item");
`endif

endmodule

FILE: rtl/qedc_merge.sv
// ----------------------------------------------------------------------------
// qedc_merge
// Gathers the lane counts into one result item and holds it in the output
// register until taken.
// ----------------------------------------------------------------------------
module qedc_merge #(
   parameter int unsigned NUM_ENCODERS = 4,
   parameter int unsigned COUNT_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [COUNT_BITS-1:0] counts [NUM_ENCODERS],
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [qedc_pkg::OUT_CHANNELS*qedc_pkg::OUT_BITS-1:0] rsp_tdata
);

   localparam int unsigned OB = qedc_pkg::OUT_BITS;

   logic                                           valid_ff;
   logic                                           valid_in;
   logic [qedc_pkg::OUT_CHANNELS*OB-1:0]           data_ff;
   logic [qedc_pkg::OUT_CHANNELS*OB-1:0]           data_in;

   for (genvar k = 0; k < qedc_pkg::OUT_CHANNELS; k++) begin : g_field
      if (k < NUM_ENCODERS) begin : g_live
         if (COUNT_BITS >= OB) begin : g_trim
            assign data_in[k*OB +: OB] = counts[k][OB-1:0];
         end else begin : g_ext
            assign data_in[k*OB +: OB] = {{(OB-COUNT_BITS){1'b0}}, counts[k]};
         end
      end else begin : g_absent
         assign data_in[k*OB +: OB] = '0;
      end
   end

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: rtl/quad_encoder_detent_counter.sv
// ----------------------------------------------------------------------------
// quad_encoder_detent_counter
// Four-channel quadrature encoder decoder with sub-step accumulation and
// detent counting.
// ----------------------------------------------------------------------------
// One item is taken per clock and one result item leaves for each, in the
// next cycle, from an output register; every channel has its own lookup, add and
// compare lane, all updated in the cycle the item is accepted, so the rate
// is one item per cycle while the result side keeps taking. The user must write registers
// through the csr port only while no item is in flight; the block does not enforce this.
// Index 0 is invert_mask, index 1 is detent_threshold, other indexes are ignored.
module quad_encoder_detent_counter #(
   parameter int unsigned NUM_ENCODERS = 4,
   parameter int unsigned COUNT_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pin_sample[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // count_0, count_1, count_2, count_3 (16 bits each)
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [qedc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [qedc_pkg::CSR_DATA_BITS-1:0] csr_data
);

   logic [qedc_pkg::MASK_BITS-1:0] invert_mask_ff;
   logic [qedc_pkg::THR_BITS-1:0]  threshold_ff;
   logic                           can_load;
   logic                           accept;
   logic [COUNT_BITS-1:0]          count_next [NUM_ENCODERS];

   assign csr_ready  = 1'b1;
   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_mask_ff <= qedc_pkg::INVERT_MASK_RESET;
         threshold_ff   <= qedc_pkg::DETENT_THRESHOLD_RESET;
      end else if (csr_valid) begin
         if (csr_index == qedc_pkg::CSR_INVERT_MASK) begin
            invert_mask_ff <= csr_data[qedc_pkg::MASK_BITS-1:0];
         end else if (csr_index == qedc_pkg::CSR_DETENT_THRESHOLD) begin
            threshold_ff <= csr_data[qedc_pkg::THR_BITS-1:0];
         end
      end
   end

   for (genvar k = 0; k < NUM_ENCODERS; k++) begin : g_lane
      localparam logic [2:0] SH = qedc_pkg::pin_shift(2'(k % 4));
      qedc_pkg::lane_ctrl_type ctrl;

      assign ctrl.advance   = accept;
      assign ctrl.invert    = invert_mask_ff[k % 4];
      assign ctrl.threshold = threshold_ff;

      qedc_lane #(
         .COUNT_BITS(COUNT_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .phase     (req_tdata[SH +: qedc_pkg::PHASE_BITS]),
         .count_next(count_next[k])
      );
   end

   qedc_merge #(
      .NUM_ENCODERS(NUM_ENCODERS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .counts    (count_next),
      .can_load  (can_load),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled with the output free");
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");
   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result appeared without an item");
`endif

endmodule
